/* rtl/dsrcm_pkg.sv */
// Shared types, codes and helpers for the dual-source raster cell merge unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package dsrcm_pkg;

  localparam int CNT_W   = 21;
  localparam int SUM_W   = 45;
  localparam int SQ_W    = 63;
  localparam int LIMIT_W = 24;
  localparam int LIN_W   = 4;
  localparam int CLS_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CLS_W-1:0] CLS_ACTIVE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_OUTSIDE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATHY_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT     = 2'd2;

  localparam logic [LIN_W-1:0] LIN_OUTSIDE        = 4'd0;
  localparam logic [LIN_W-1:0] LIN_EXCLUDED       = 4'd1;
  localparam logic [LIN_W-1:0] LIN_BATHY          = 4'd2;
  localparam logic [LIN_W-1:0] LIN_TOPO           = 4'd3;
  localparam logic [LIN_W-1:0] LIN_OVL_BATHY      = 4'd4;
  localparam logic [LIN_W-1:0] LIN_OVL_BATHY_CONF = 4'd5;
  localparam logic [LIN_W-1:0] LIN_OVL_TOPO       = 4'd6;
  localparam logic [LIN_W-1:0] LIN_OVL_TOPO_CONF  = 4'd7;
  localparam logic [LIN_W-1:0] LIN_UNRESOLVED     = 4'd8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd256;

  typedef struct packed {
    logic             first;
    logic             merged_valid;
    logic [LIN_W-1:0] lineage;
    logic             bump_overlap;
    logic             bump_conflict;
    logic             bump_bathy;
    logic             bump_topo;
    logic             bump_unresolved;
    logic             set_error;
  } cell_flags_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    res = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + 1'b1;
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/dsrcm_select.sv */
// Input register and cell classification stage: difference, magnitude, limit
// check, source choice and lineage. Depends on dsrcm_pkg.
`default_nettype none

module dsrcm_select #(
  parameter int VALUE_BITS = 24
) (
  input  wire                                clk,
  input  wire                                in_load,
  input  wire                                stage_load,
  input  wire                                in_first_cell,
  input  wire  [dsrcm_pkg::CLS_W-1:0]        in_cell_class,
  input  wire                                in_bathy_valid,
  input  wire                                in_topo_valid,
  input  wire  signed [VALUE_BITS-1:0]       in_bathy_value,
  input  wire  signed [VALUE_BITS-1:0]       in_topo_value,
  input  wire  [dsrcm_pkg::LIMIT_W-1:0]      limit,
  input  wire                                bathy_first,
  input  wire                                reject_mode,
  output dsrcm_pkg::cell_flags_t             flags_r,
  output logic signed [VALUE_BITS-1:0]       merged_r,
  output logic signed [VALUE_BITS:0]         diff_r,
  output logic [VALUE_BITS-1:0]              mag_r
);
  import dsrcm_pkg::*;

  localparam int CMP_W = (VALUE_BITS > LIMIT_W) ? VALUE_BITS : LIMIT_W;

  logic                           first_r;
  logic [CLS_W-1:0]               cls_r;
  logic                           bv_r;
  logic                           tv_r;
  logic signed [VALUE_BITS-1:0]   bval_r;
  logic signed [VALUE_BITS-1:0]   tval_r;

  logic signed [VALUE_BITS:0]     tb_diff;
  logic signed [VALUE_BITS:0]     bt_diff;
  logic [VALUE_BITS-1:0]          mag;
  logic                           conflict;
  cell_flags_t                    flags_nxt;
  logic signed [VALUE_BITS-1:0]   merged_nxt;

  always_ff @(posedge clk) begin
    if (in_load) begin
      first_r <= in_first_cell;
      cls_r   <= in_cell_class;
      bv_r    <= in_bathy_valid;
      tv_r    <= in_topo_valid;
      bval_r  <= in_bathy_value;
      tval_r  <= in_topo_value;
    end
  end

  assign tb_diff  = {tval_r[VALUE_BITS-1], tval_r} - {bval_r[VALUE_BITS-1], bval_r};
  assign bt_diff  = {bval_r[VALUE_BITS-1], bval_r} - {tval_r[VALUE_BITS-1], tval_r};
  assign mag      = tb_diff[VALUE_BITS] ? bt_diff[VALUE_BITS-1:0] : tb_diff[VALUE_BITS-1:0];
  assign conflict = CMP_W'(mag) > CMP_W'(limit);

  always_comb begin
    flags_nxt                 = '0;
    flags_nxt.first           = first_r;
    merged_nxt                = '0;
    case (cls_r)
      CLS_ACTIVE: begin
        if (bv_r && tv_r) begin
          flags_nxt.merged_valid  = 1'b1;
          flags_nxt.bump_overlap  = 1'b1;
          flags_nxt.bump_conflict = conflict;
          flags_nxt.set_error     = conflict && reject_mode;
          if (bathy_first) begin
            merged_nxt           = bval_r;
            flags_nxt.bump_bathy = 1'b1;
            flags_nxt.lineage    = conflict ? LIN_OVL_BATHY_CONF : LIN_OVL_BATHY;
          end else begin
            merged_nxt          = tval_r;
            flags_nxt.bump_topo = 1'b1;
            flags_nxt.lineage   = conflict ? LIN_OVL_TOPO_CONF : LIN_OVL_TOPO;
          end
        end else if (bv_r) begin
          merged_nxt             = bval_r;
          flags_nxt.merged_valid = 1'b1;
          flags_nxt.bump_bathy   = 1'b1;
          flags_nxt.lineage      = LIN_BATHY;
        end else if (tv_r) begin
          merged_nxt             = tval_r;
          flags_nxt.merged_valid = 1'b1;
          flags_nxt.bump_topo    = 1'b1;
          flags_nxt.lineage      = LIN_TOPO;
        end else begin
          flags_nxt.bump_unresolved = 1'b1;
          flags_nxt.lineage         = LIN_UNRESOLVED;
        end
      end
      CLS_OUTSIDE: flags_nxt.lineage = LIN_OUTSIDE;
      default:     flags_nxt.lineage = LIN_EXCLUDED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      flags_r  <= flags_nxt;
      merged_r <= merged_nxt;
      diff_r   <= tb_diff;
      mag_r    <= mag;
    end
  end

endmodule

`default_nettype wire

/* rtl/dsrcm_square.sv */
// Squaring stage: registers the squared overlap difference and carries the
// rest of the cell along. Depends on dsrcm_pkg.
`default_nettype none

module dsrcm_square #(
  parameter int VALUE_BITS = 24
) (
  input  wire                                clk,
  input  wire                                stage_load,
  input  dsrcm_pkg::cell_flags_t             flags,
  input  wire  signed [VALUE_BITS-1:0]       merged,
  input  wire  signed [VALUE_BITS:0]         diff,
  input  wire  [VALUE_BITS-1:0]              mag,
  output dsrcm_pkg::cell_flags_t             flags_r,
  output logic signed [VALUE_BITS-1:0]       merged_r,
  output logic signed [VALUE_BITS:0]         diff_r,
  output logic [VALUE_BITS-1:0]              mag_r,
  output logic [2*VALUE_BITS-1:0]            square_r
);
  import dsrcm_pkg::*;

  logic [2*VALUE_BITS-1:0] square;

  assign square = (2*VALUE_BITS)'(mag) * (2*VALUE_BITS)'(mag);

  always_ff @(posedge clk) begin
    if (stage_load) begin
      flags_r  <= flags;
      merged_r <= merged;
      diff_r   <= diff;
      mag_r    <= mag;
      square_r <= square;
    end
  end

endmodule

`default_nettype wire

/* rtl/dsrcm_stats.sv */
// Statistics stage and result register: counters, difference sums, peak and
// sticky error, updated as each cell enters the result register. Depends on dsrcm_pkg.
`default_nettype none

module dsrcm_stats #(
  parameter int VALUE_BITS = 24
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                out_load,
  input  dsrcm_pkg::cell_flags_t             flags,
  input  wire  signed [VALUE_BITS-1:0]       merged,
  input  wire  signed [VALUE_BITS:0]         diff,
  input  wire  [VALUE_BITS-1:0]              mag,
  input  wire  [2*VALUE_BITS-1:0]            square,
  output logic signed [VALUE_BITS-1:0]       merged_value_r,
  output logic                               merged_valid_r,
  output logic [dsrcm_pkg::LIN_W-1:0]        lineage_r,
  output logic                               error_r,
  output logic [dsrcm_pkg::CNT_W-1:0]        overlap_r,
  output logic [dsrcm_pkg::CNT_W-1:0]        conflict_r,
  output logic [dsrcm_pkg::CNT_W-1:0]        bathy_r,
  output logic [dsrcm_pkg::CNT_W-1:0]        topo_r,
  output logic [dsrcm_pkg::CNT_W-1:0]        unresolved_r,
  output logic signed [dsrcm_pkg::SUM_W-1:0] diff_sum_r,
  output logic [dsrcm_pkg::SQ_W-1:0]         square_sum_r,
  output logic [VALUE_BITS-1:0]              peak_r
);
  import dsrcm_pkg::*;

  localparam int SQ_SUM_W = SQ_W + 2;

  logic                     base_error;
  logic [CNT_W-1:0]         base_overlap;
  logic [CNT_W-1:0]         base_conflict;
  logic [CNT_W-1:0]         base_bathy;
  logic [CNT_W-1:0]         base_topo;
  logic [CNT_W-1:0]         base_unresolved;
  logic signed [SUM_W-1:0]  base_diff_sum;
  logic [SQ_W-1:0]          base_square_sum;
  logic [VALUE_BITS-1:0]    base_peak;
  logic [SQ_SUM_W-1:0]      square_total;

  logic                     error_nxt;
  logic [CNT_W-1:0]         overlap_nxt;
  logic [CNT_W-1:0]         conflict_nxt;
  logic [CNT_W-1:0]         bathy_nxt;
  logic [CNT_W-1:0]         topo_nxt;
  logic [CNT_W-1:0]         unresolved_nxt;
  logic signed [SUM_W-1:0]  diff_sum_nxt;
  logic [SQ_W-1:0]          square_sum_nxt;
  logic [VALUE_BITS-1:0]    peak_nxt;

  // A first cell starts its grid from cleared statistics.
  always_comb begin
    base_error      = flags.first ? 1'b0 : error_r;
    base_overlap    = flags.first ? '0 : overlap_r;
    base_conflict   = flags.first ? '0 : conflict_r;
    base_bathy      = flags.first ? '0 : bathy_r;
    base_topo       = flags.first ? '0 : topo_r;
    base_unresolved = flags.first ? '0 : unresolved_r;
    base_diff_sum   = flags.first ? '0 : diff_sum_r;
    base_square_sum = flags.first ? '0 : square_sum_r;
    base_peak       = flags.first ? '0 : peak_r;
  end

  assign square_total = SQ_SUM_W'(base_square_sum) + SQ_SUM_W'(square);

  always_comb begin
    error_nxt      = base_error | flags.set_error;
    overlap_nxt    = flags.bump_overlap ? cnt_inc(base_overlap) : base_overlap;
    conflict_nxt   = flags.bump_conflict ? cnt_inc(base_conflict) : base_conflict;
    bathy_nxt      = flags.bump_bathy ? cnt_inc(base_bathy) : base_bathy;
    topo_nxt       = flags.bump_topo ? cnt_inc(base_topo) : base_topo;
    unresolved_nxt = flags.bump_unresolved ? cnt_inc(base_unresolved) : base_unresolved;
    diff_sum_nxt   = base_diff_sum;
    square_sum_nxt = base_square_sum;
    peak_nxt       = base_peak;
    if (flags.bump_overlap) begin
      diff_sum_nxt = base_diff_sum + SUM_W'(diff);
      if (square_total[SQ_SUM_W-1:SQ_W] != 2'b00) begin
        square_sum_nxt = {SQ_W{1'b1}};
      end else begin
        square_sum_nxt = square_total[SQ_W-1:0];
      end
      if (mag > base_peak) begin
        peak_nxt = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_r      <= 1'b0;
      overlap_r    <= '0;
      conflict_r   <= '0;
      bathy_r      <= '0;
      topo_r       <= '0;
      unresolved_r <= '0;
      diff_sum_r   <= '0;
      square_sum_r <= '0;
      peak_r       <= '0;
    end else if (out_load) begin
      error_r      <= error_nxt;
      overlap_r    <= overlap_nxt;
      conflict_r   <= conflict_nxt;
      bathy_r      <= bathy_nxt;
      topo_r       <= topo_nxt;
      unresolved_r <= unresolved_nxt;
      diff_sum_r   <= diff_sum_nxt;
      square_sum_r <= square_sum_nxt;
      peak_r       <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      merged_value_r <= merged;
      merged_valid_r <= flags.merged_valid;
      lineage_r      <= flags.lineage;
    end
  end

endmodule

`default_nettype wire

/* rtl/dual_source_raster_cell_merge_unit.sv */
// Top level of the dual-source raster cell merge unit: configuration registers,
// pipeline valid tracking and the three stage modules. Depends on dsrcm_pkg.
//
//   Channel   Direction  Handshake              Content
//   in_*      input      in_valid / in_stall    one grid cell with two samples
//   out_*     output     out_valid / out_stall  merged cell and running statistics
//   cfg_*     input      cfg_we                 limit, source priority, reject mode
//
// One cell is accepted per cycle while in_stall is low; its result word becomes valid
// once the cell has passed the classify and square registers into the result register.
// The pipeline is input register, classify, square, then statistics update
// into the result register; the running statistics live in that last stage.
// Reset is synchronous; it clears the pipeline and statistics and sets the configuration to its defaults.
// A stall empties bubbles first, so in_stall rises only when every stage is full.
`default_nettype none

module dual_source_raster_cell_merge_unit #(
  parameter int VALUE_BITS = 24
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [dsrcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dsrcm_pkg::LIMIT_W-1:0]      cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_first_cell,
  input  wire  [dsrcm_pkg::CLS_W-1:0]        in_cell_class,
  input  wire                                in_bathy_valid,
  input  wire                                in_topo_valid,
  input  wire  signed [VALUE_BITS-1:0]       in_bathy_value,
  input  wire  signed [VALUE_BITS-1:0]       in_topo_value,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [VALUE_BITS-1:0]       out_merged_value,
  output logic                               out_merged_valid,
  output logic [dsrcm_pkg::LIN_W-1:0]        out_lineage_code,
  output logic                               out_reject_error,
  output logic [dsrcm_pkg::CNT_W-1:0]        out_overlap_count,
  output logic [dsrcm_pkg::CNT_W-1:0]        out_conflict_count,
  output logic [dsrcm_pkg::CNT_W-1:0]        out_bathy_selected_count,
  output logic [dsrcm_pkg::CNT_W-1:0]        out_topo_selected_count,
  output logic [dsrcm_pkg::CNT_W-1:0]        out_unresolved_count,
  output logic signed [dsrcm_pkg::SUM_W-1:0] out_diff_sum,
  output logic [dsrcm_pkg::SQ_W-1:0]         out_diff_square_sum,
  output logic [VALUE_BITS-1:0]              out_max_abs_diff
);
  import dsrcm_pkg::*;

  logic [LIMIT_W-1:0]           limit_r;
  logic                         bathy_first_r;
  logic                         reject_r;

  logic                         in_stage_valid_r;
  logic                         sel_stage_valid_r;
  logic                         sq_stage_valid_r;
  logic                         out_valid_r;

  logic                         out_load;
  logic                         sq_load;
  logic                         sel_load;
  logic                         in_load;

  cell_flags_t                  sel_flags;
  logic signed [VALUE_BITS-1:0] sel_merged;
  logic signed [VALUE_BITS:0]   sel_diff;
  logic [VALUE_BITS-1:0]        sel_mag;

  cell_flags_t                  sq_flags;
  logic signed [VALUE_BITS-1:0] sq_merged;
  logic signed [VALUE_BITS:0]   sq_diff;
  logic [VALUE_BITS-1:0]        sq_mag;
  logic [2*VALUE_BITS-1:0]      sq_square;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= LIMIT_RESET;
      bathy_first_r <= 1'b1;
      reject_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT:       limit_r       <= cfg_data;
        CFG_BATHY_FIRST: bathy_first_r <= cfg_data[0];
        CFG_REJECT:      reject_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_load = sq_stage_valid_r && (!out_valid_r || !out_stall);
  assign sq_load  = !sq_stage_valid_r || out_load;
  assign sel_load = !sel_stage_valid_r || sq_load;
  assign in_load  = !in_stage_valid_r || sel_load;
  assign in_stall = !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stage_valid_r  <= 1'b0;
      sel_stage_valid_r <= 1'b0;
      sq_stage_valid_r  <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_load) begin
        in_stage_valid_r <= in_valid;
      end
      if (sel_load) begin
        sel_stage_valid_r <= in_stage_valid_r;
      end
      if (sq_load) begin
        sq_stage_valid_r <= sel_stage_valid_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  dsrcm_select #(
    .VALUE_BITS(VALUE_BITS)
  ) u_select (
    .clk            (clk),
    .in_load        (in_load),
    .stage_load     (sel_load),
    .in_first_cell  (in_first_cell),
    .in_cell_class  (in_cell_class),
    .in_bathy_valid (in_bathy_valid),
    .in_topo_valid  (in_topo_valid),
    .in_bathy_value (in_bathy_value),
    .in_topo_value  (in_topo_value),
    .limit          (limit_r),
    .bathy_first    (bathy_first_r),
    .reject_mode    (reject_r),
    .flags_r        (sel_flags),
    .merged_r       (sel_merged),
    .diff_r         (sel_diff),
    .mag_r          (sel_mag)
  );

  dsrcm_square #(
    .VALUE_BITS(VALUE_BITS)
  ) u_square (
    .clk        (clk),
    .stage_load (sq_load),
    .flags      (sel_flags),
    .merged     (sel_merged),
    .diff       (sel_diff),
    .mag        (sel_mag),
    .flags_r    (sq_flags),
    .merged_r   (sq_merged),
    .diff_r     (sq_diff),
    .mag_r      (sq_mag),
    .square_r   (sq_square)
  );

  dsrcm_stats #(
    .VALUE_BITS(VALUE_BITS)
  ) u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_load       (out_load),
    .flags          (sq_flags),
    .merged         (sq_merged),
    .diff           (sq_diff),
    .mag            (sq_mag),
    .square         (sq_square),
    .merged_value_r (out_merged_value),
    .merged_valid_r (out_merged_valid),
    .lineage_r      (out_lineage_code),
    .error_r        (out_reject_error),
    .overlap_r      (out_overlap_count),
    .conflict_r     (out_conflict_count),
    .bathy_r        (out_bathy_selected_count),
    .topo_r         (out_topo_selected_count),
    .unresolved_r   (out_unresolved_count),
    .diff_sum_r     (out_diff_sum),
    .square_sum_r   (out_diff_square_sum),
    .peak_r         (out_max_abs_diff)
  );

endmodule

`default_nettype wire

/* verif/dual_source_raster_cell_merge_unit_tb.sv */
// Self-checking testbench for dual_source_raster_cell_merge_unit: it predicts each merged
// word and the running statistics, and checks every result under random idling.
// Depends on dsrcm_pkg and the RTL top level only.
`default_nettype none

module dual_source_raster_cell_merge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrcm_pkg::*;

  localparam int VB = 24;
  localparam int PIPE_DEPTH = 4;
  localparam int RAND_ITEMS = 532;
  localparam int MAX_REPORTS = 60;

  localparam logic [CLS_W-1:0] CLS_EXCLUDED = 2'd2;
  localparam logic [CLS_W-1:0] CLS_UNUSED = 2'd3;

  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
  localparam longint VMAX_L = 64'sd8388607;
  localparam longint VMIN_L = -64'sd8388608;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = {LIMIT_W{1'b1}};
  localparam logic [63:0] SQ_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint PEAK_TOP = (64'sd1 <<< VB) - 1;

  typedef struct {
    logic                   first;
    logic [CLS_W-1:0]       cls;
    logic                   bv;
    logic                   tv;
    logic signed [VB-1:0]   bval;
    logic signed [VB-1:0]   tval;
  } cell_t;

  typedef struct {
    logic [VB-1:0]    merged;
    logic             mvalid;
    logic [LIN_W-1:0] lineage;
    logic             err;
    logic [CNT_W-1:0] n_overlap;
    logic [CNT_W-1:0] n_conflict;
    logic [CNT_W-1:0] n_bathy;
    logic [CNT_W-1:0] n_topo;
    logic [CNT_W-1:0] n_unres;
    logic [SUM_W-1:0] diff_sum;
    logic [SQ_W-1:0]  sq_sum;
    logic [VB-1:0]    peak;
  } merge_result_t;

  class merge_predictor;
    logic [LIMIT_W-1:0] limit;
    logic               bathy_first;
    logic               reject_mode;
    logic [CNT_W-1:0]   n_overlap, n_conflict, n_bathy, n_topo, n_unres;
    logic [SUM_W-1:0]   diff_acc;
    logic [SQ_W-1:0]    sq_acc;
    logic [VB-1:0]      peak;
    logic               err;
    merge_result_t      expected_merges[$];
    int                 errors;

    function new();
      limit = LIMIT_RESET;
      bathy_first = 1'b1;
      reject_mode = 1'b0;
      errors = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      n_overlap = '0;
      n_conflict = '0;
      n_bathy = '0;
      n_topo = '0;
      n_unres = '0;
      diff_acc = '0;
      sq_acc = '0;
      peak = '0;
      err = 1'b0;
    endfunction

    function logic [CNT_W-1:0] bump_sat(logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
      case (idx)
        CFG_LIMIT:       limit = data;
        CFG_BATHY_FIRST: bathy_first = data[0];
        CFG_REJECT:      reject_mode = data[0];
        default: ;
      endcase
    endfunction

    function void accept_sample(cell_t c);
      merge_result_t r;
      longint b, t, d, m, capped;
      logic [63:0] sq;
      logic conflict;
      b = longint'(c.bval);
      t = longint'(c.tval);
      r.merged = '0;
      r.mvalid = 1'b0;
      if (c.first) clear_stats();
      if (c.cls == CLS_OUTSIDE) begin
        r.lineage = LIN_OUTSIDE;
      end else if (c.cls != CLS_ACTIVE) begin
        r.lineage = LIN_EXCLUDED;
      end else if (c.bv && c.tv) begin
        d = t - b;
        m = (d < 0) ? -d : d;
        conflict = (m > longint'({40'd0, limit}));
        n_overlap = bump_sat(n_overlap);
        diff_acc = diff_acc + d[SUM_W-1:0];
        sq = m * m;
        if ({1'b0, sq_acc} > SQ_TOP - sq) sq_acc = SQ_TOP[SQ_W-1:0];
        else sq_acc = sq_acc + sq[SQ_W-1:0];
        capped = (m > PEAK_TOP) ? PEAK_TOP : m;
        if (capped > longint'({40'd0, peak})) peak = capped[VB-1:0];
        if (conflict) begin
          n_conflict = bump_sat(n_conflict);
          if (reject_mode) err = 1'b1;
        end
        r.mvalid = 1'b1;
        if (bathy_first) begin
          r.merged = c.bval;
          r.lineage = conflict ? LIN_OVL_BATHY_CONF : LIN_OVL_BATHY;
          n_bathy = bump_sat(n_bathy);
        end else begin
          r.merged = c.tval;
          r.lineage = conflict ? LIN_OVL_TOPO_CONF : LIN_OVL_TOPO;
          n_topo = bump_sat(n_topo);
        end
      end else if (c.bv) begin
        r.merged = c.bval;
        r.mvalid = 1'b1;
        r.lineage = LIN_BATHY;
        n_bathy = bump_sat(n_bathy);
      end else if (c.tv) begin
        r.merged = c.tval;
        r.mvalid = 1'b1;
        r.lineage = LIN_TOPO;
        n_topo = bump_sat(n_topo);
      end else begin
        r.lineage = LIN_UNRESOLVED;
        n_unres = bump_sat(n_unres);
      end
      r.err = err;
      r.n_overlap = n_overlap;
      r.n_conflict = n_conflict;
      r.n_bathy = n_bathy;
      r.n_topo = n_topo;
      r.n_unres = n_unres;
      r.diff_sum = diff_acc;
      r.sq_sum = sq_acc;
      r.peak = peak;
      expected_merges = {expected_merges, r};
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void compare_merge(merge_result_t got);
      merge_result_t e;
      if (expected_merges.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result word: expected none, actual lineage %0d",
                   $time, got.lineage);
        return;
      end
      e = expected_merges[0];
      expected_merges.delete(0);
      check_field("merged_value", 64'(e.merged), 64'(got.merged));
      check_field("merged_valid", 64'(e.mvalid), 64'(got.mvalid));
      check_field("lineage_code", 64'(e.lineage), 64'(got.lineage));
      check_field("reject_error", 64'(e.err), 64'(got.err));
      check_field("overlap_count", 64'(e.n_overlap), 64'(got.n_overlap));
      check_field("conflict_count", 64'(e.n_conflict), 64'(got.n_conflict));
      check_field("bathy_selected_count", 64'(e.n_bathy), 64'(got.n_bathy));
      check_field("topo_selected_count", 64'(e.n_topo), 64'(got.n_topo));
      check_field("unresolved_count", 64'(e.n_unres), 64'(got.n_unres));
      check_field("diff_sum", 64'(e.diff_sum), 64'(got.diff_sum));
      check_field("diff_square_sum", 64'(e.sq_sum), 64'(got.sq_sum));
      check_field("max_abs_diff", 64'(e.peak), 64'(got.peak));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_first_cell = 1'b0;
  logic [CLS_W-1:0] in_cell_class = '0;
  logic in_bathy_valid = 1'b0;
  logic in_topo_valid = 1'b0;
  logic signed [VB-1:0] in_bathy_value = '0;
  logic signed [VB-1:0] in_topo_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VB-1:0] out_merged_value;
  logic out_merged_valid;
  logic [LIN_W-1:0] out_lineage_code;
  logic out_reject_error;
  logic [CNT_W-1:0] out_overlap_count;
  logic [CNT_W-1:0] out_conflict_count;
  logic [CNT_W-1:0] out_bathy_selected_count;
  logic [CNT_W-1:0] out_topo_selected_count;
  logic [CNT_W-1:0] out_unresolved_count;
  logic signed [SUM_W-1:0] out_diff_sum;
  logic [SQ_W-1:0] out_diff_square_sum;
  logic [VB-1:0] out_max_abs_diff;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_send[4] = '{0, 50, 0, 32};
  int idle_recv[4] = '{0, 0, 50, 32};

  merge_predictor pred = new();

  dual_source_raster_cell_merge_unit #(
    .VALUE_BITS(VB)
  ) u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_first_cell            (in_first_cell),
    .in_cell_class            (in_cell_class),
    .in_bathy_valid           (in_bathy_valid),
    .in_topo_valid            (in_topo_valid),
    .in_bathy_value           (in_bathy_value),
    .in_topo_value            (in_topo_value),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_merged_value         (out_merged_value),
    .out_merged_valid         (out_merged_valid),
    .out_lineage_code         (out_lineage_code),
    .out_reject_error         (out_reject_error),
    .out_overlap_count        (out_overlap_count),
    .out_conflict_count       (out_conflict_count),
    .out_bathy_selected_count (out_bathy_selected_count),
    .out_topo_selected_count  (out_topo_selected_count),
    .out_unresolved_count     (out_unresolved_count),
    .out_diff_sum             (out_diff_sum),
    .out_diff_square_sum      (out_diff_square_sum),
    .out_max_abs_diff         (out_max_abs_diff)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : result_monitor
    merge_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.merged = out_merged_value;
      got.mvalid = out_merged_valid;
      got.lineage = out_lineage_code;
      got.err = out_reject_error;
      got.n_overlap = out_overlap_count;
      got.n_conflict = out_conflict_count;
      got.n_bathy = out_bathy_selected_count;
      got.n_topo = out_topo_selected_count;
      got.n_unres = out_unresolved_count;
      got.diff_sum = out_diff_sum;
      got.sq_sum = out_diff_square_sum;
      got.peak = out_max_abs_diff;
      pred.compare_merge(got);
    end
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic cell_t mk(logic first, logic [CLS_W-1:0] cls, logic bv, logic tv,
                               logic signed [VB-1:0] b, logic signed [VB-1:0] t);
    cell_t c;
    c.first = first;
    c.cls = cls;
    c.bv = bv;
    c.tv = tv;
    c.bval = b;
    c.tval = t;
    return c;
  endfunction

  function automatic logic signed [VB-1:0] random_elevation();
    logic signed [VB-1:0] v;
    case ($urandom_range(3))
      0, 1: v = VB'($urandom());
      2: begin
        case ($urandom_range(3))
          0: v = VMAX;
          1: v = VMIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = VB'(int'($urandom_range(600)) - 300);
    endcase
    return v;
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int pick;
    longint b, t, d;
    c.first = ($urandom_range(99) < 3);
    pick = $urandom_range(99);
    if (pick < 75) c.cls = CLS_ACTIVE;
    else if (pick < 83) c.cls = CLS_OUTSIDE;
    else if (pick < 92) c.cls = CLS_EXCLUDED;
    else c.cls = CLS_UNUSED;
    pick = $urandom_range(99);
    c.bv = (pick < 70);
    c.tv = (pick < 50) || (pick >= 70 && pick < 90);
    c.bval = random_elevation();
    c.tval = random_elevation();
    if (c.bv && c.tv && $urandom_range(1)) begin
      b = longint'(c.bval);
      d = longint'({40'd0, pred.limit}) + longint'($urandom_range(2)) - 1;
      if ($urandom_range(1)) d = -d;
      t = b + d;
      if (t > VMAX_L || t < VMIN_L) t = b - d;
      if (t > VMAX_L || t < VMIN_L) t = longint'(c.tval);
      c.tval = t[VB-1:0];
    end
    return c;
  endfunction

  task automatic send_cell(cell_t c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_cell <= c.first;
    in_cell_class <= c.cls;
    in_bathy_valid <= c.bv;
    in_topo_valid <= c.tv;
    in_bathy_value <= c.bval;
    in_topo_value <= c.tval;
    do @(posedge clk); while (in_stall);
    pred.accept_sample(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pred.expected_merges.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    pred.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_flag(logic [CFG_IDX_W-1:0] idx, logic flag);
    logic [LIMIT_W-1:0] data;
    data = LIMIT_W'($urandom());
    data[0] = flag;
    write_reg(idx, data);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cell(mk(1'b1, CLS_ACTIVE, 1'b1, 1'b1, VB'(0), VB'(256)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VB'(100), VB'(357)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VB'(357), VB'(100)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b0, VMAX, VMIN));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b0, 1'b1, VMAX, VMIN));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b0, 1'b0, VB'(-1), VB'(-1)));
    send_cell(mk(1'b0, CLS_OUTSIDE, 1'b1, 1'b1, VB'(5), VB'(9)));
    send_cell(mk(1'b0, CLS_EXCLUDED, 1'b1, 1'b1, VB'(5), VB'(9)));
    send_cell(mk(1'b0, CLS_UNUSED, 1'b0, 1'b1, VB'(5), VB'(9)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VMIN, VMAX));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VMAX, VMIN));
    drain();
    write_reg(CFG_LIMIT, '0);
    write_flag(CFG_BATHY_FIRST, 1'b0);
    write_flag(CFG_REJECT, 1'b1);
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VB'(-7), VB'(-7)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VB'(-7), VB'(-6)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b0, VB'(3), VB'(3)));
    send_cell(mk(1'b1, CLS_ACTIVE, 1'b0, 1'b1, VB'(3), VB'(3)));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VB'(0), VB'(1)));
    drain();
    write_reg(CFG_LIMIT, LIMIT_TOP);
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VMIN, VMAX));
    send_cell(mk(1'b0, CLS_ACTIVE, 1'b1, 1'b1, VMAX, VMIN));

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(CFG_LIMIT, '0);
          write_flag(CFG_BATHY_FIRST, 1'b1);
          write_flag(CFG_REJECT, 1'b1);
        end
        1: begin
          write_reg(CFG_LIMIT, LIMIT_TOP);
          write_flag(CFG_BATHY_FIRST, 1'b0);
          write_flag(CFG_REJECT, 1'b0);
        end
        2: begin
          write_reg(CFG_LIMIT, LIMIT_W'($urandom_range(4096)));
          write_flag(CFG_BATHY_FIRST, 1'b1);
          write_flag(CFG_REJECT, 1'b1);
        end
        default: begin
          write_reg(CFG_LIMIT, LIMIT_W'($urandom()));
          write_flag(CFG_BATHY_FIRST, 1'b0);
          write_flag(CFG_REJECT, 1'b1);
        end
      endcase
      send_idle_pct = idle_send[p];
      stall_pct = idle_recv[p];
      repeat (RAND_ITEMS / 4) send_cell(random_cell());
    end
    drain();

    if (pred.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
